// ----- rtl/xor_frame_receiver_macros.svh -----
// ----------------------------------------------------------------------------
// xor frame receiver assertion macros
// shared concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef XOR_FRAME_RECEIVER_MACROS_SVH
`define XOR_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH

// property checked on rising clock, held off while reset is asserted
`define XFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on rising clock, also during reset
`define XFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define XFR_ASSERT(lbl, clk, rstn, prop, msg)
`define XFR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/xfr_pkg.sv -----
// ----------------------------------------------------------------------------
// xfr_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xfr_pkg;

  localparam int unsigned MaxPayload = 32;
  localparam int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 6;
  localparam int unsigned IdxW       = 5;

  localparam logic [ByteW-1:0] SyncReset = 8'hA5;

  // controller to datapath
  typedef struct packed {
    logic load_cmd;    // capture command byte, seed checksum
    logic load_len;    // capture length byte, clear fill count
    logic write_data;  // store payload byte at fill count
    logic start_emit;  // rewind release index
    logic issue_read;  // read payload store at release index
    logic load_out;    // load output register, advance release index
  } xfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sync_hit;      // input byte equals sync byte
    logic len_ok;        // input byte is a legal length
    logic len_zero;      // input byte is zero
    logic data_done;     // this payload byte is the final one
    logic xor_match;     // input byte equals running checksum
    logic held_len_zero; // held frame has no payload
    logic last_idx;      // release index is the final payload byte
    logic out_free;      // output register can take a new result
  } xfr_sts_t;

endpackage

`default_nettype wire

// ----- rtl/xfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// xfr_ctrl
// frame sequencing state machine: hunt, header, payload, check, release
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xor_frame_receiver_macros.svh"

module xfr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire xfr_pkg::xfr_sts_t sts_i,
  output xfr_pkg::xfr_cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    StHunt   = 7'b0000001,
    StCmd    = 7'b0000010,
    StLen    = 7'b0000100,
    StData   = 7'b0001000,
    StCheck  = 7'b0010000,
    StEmitRd = 7'b0100000,
    StEmitLd = 7'b1000000
  } xfr_state_e;

  xfr_state_e state_q, state_d;
  logic       accept;

  // input is taken in every state outside the release burst
  assign accept = in_valid_i & ~((state_q == StEmitRd) | (state_q == StEmitLd));

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StHunt: begin
        in_ready_o = 1'b1;
        if (accept && sts_i.sync_hit) begin
          state_d = StCmd;
        end
      end
      StCmd: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = StLen;
        end
      end
      StLen: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (sts_i.len_ok) begin
            cmd_o.load_len = 1'b1;
            state_d        = sts_i.len_zero ? StCheck : StData;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StData: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.write_data = 1'b1;
          if (sts_i.data_done) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (sts_i.xor_match) begin
            cmd_o.start_emit = 1'b1;
            state_d          = sts_i.held_len_zero ? StEmitLd : StEmitRd;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StEmitRd: begin
        cmd_o.issue_read = 1'b1;
        state_d          = StEmitLd;
      end
      StEmitLd: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.held_len_zero || sts_i.last_idx) begin
            state_d = StHunt;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is only loaded when the output register has room
  `XFR_ASSERT(a_load_needs_room, clk_i, rst_ni, cmd_o.load_out |-> sts_i.out_free, "load while output full")
  // every store read is followed by a load attempt on the next cycle
  `XFR_ASSERT(a_read_then_load, clk_i, rst_ni, cmd_o.issue_read |=> (state_q == StEmitLd), "read not followed by load")
  // no input transfer while a release burst is running
  `XFR_ASSERT(a_no_accept_in_burst, clk_i, rst_ni, (state_q == StEmitRd || state_q == StEmitLd) |-> !in_ready_o, "input taken during release")

endmodule

`default_nettype wire

// ----- rtl/xfr_datapath.sv -----
// ----------------------------------------------------------------------------
// xfr_datapath
// header registers, running checksum, payload store and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xor_frame_receiver_macros.svh"

module xfr_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [xfr_pkg::ByteW-1:0]  cfg_wdata_i,
  input  wire logic [xfr_pkg::ByteW-1:0]  rx_data_i,
  input  wire xfr_pkg::xfr_cmd_t          cmd_i,
  output xfr_pkg::xfr_sts_t               sts_o,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [xfr_pkg::ByteW-1:0]       frame_command_o,
  output logic [xfr_pkg::LenW-1:0]        frame_length_o,
  output logic [xfr_pkg::IdxW-1:0]        byte_index_o,
  output logic [xfr_pkg::ByteW-1:0]       payload_byte_o,
  output logic                            has_data_o,
  output logic                            last_o
);

  logic [xfr_pkg::ByteW-1:0] sync_q;
  logic [xfr_pkg::ByteW-1:0] cmd_q;
  logic [xfr_pkg::CntW-1:0]  len_q;
  logic [xfr_pkg::CntW-1:0]  fill_q;
  logic [xfr_pkg::ByteW-1:0] xor_q;
  logic [xfr_pkg::AddrW-1:0] idx_q;
  logic [xfr_pkg::ByteW-1:0] rdata_q;

  logic [xfr_pkg::ByteW-1:0] mem [xfr_pkg::MaxPayload];

  logic                      out_valid_q;
  logic [xfr_pkg::ByteW-1:0] out_cmd_q;
  logic [xfr_pkg::LenW-1:0]  out_len_q;
  logic [xfr_pkg::IdxW-1:0]  out_idx_q;
  logic [xfr_pkg::ByteW-1:0] out_byte_q;
  logic                      out_has_q;
  logic                      out_last_q;

  logic [xfr_pkg::CntW-1:0]  fill_inc;
  logic [xfr_pkg::CntW-1:0]  idx_inc;
  logic                      held_zero;

  assign fill_inc  = fill_q + xfr_pkg::CntW'(1);
  assign idx_inc   = xfr_pkg::CntW'(idx_q) + xfr_pkg::CntW'(1);
  assign held_zero = (len_q == '0);

  always_comb begin
    sts_o               = '0;
    sts_o.sync_hit      = (rx_data_i == sync_q);
    sts_o.len_ok        = ({1'b0, rx_data_i} <= 9'(xfr_pkg::MaxPayload));
    sts_o.len_zero      = (rx_data_i == '0);
    sts_o.data_done     = (fill_inc >= len_q);
    sts_o.xor_match     = (rx_data_i == xor_q);
    sts_o.held_len_zero = held_zero;
    sts_o.last_idx      = (idx_inc == len_q);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  // configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= xfr_pkg::SyncReset;
      cmd_q       <= '0;
      len_q       <= '0;
      fill_q      <= '0;
      xor_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
      if (cmd_i.load_cmd) begin
        cmd_q <= rx_data_i;
        xor_q <= rx_data_i;
      end
      if (cmd_i.load_len) begin
        len_q  <= xfr_pkg::CntW'(rx_data_i);
        fill_q <= '0;
        xor_q  <= xor_q ^ rx_data_i;
      end
      if (cmd_i.write_data) begin
        fill_q <= fill_inc;
        xor_q  <= xor_q ^ rx_data_i;
      end
      if (cmd_i.start_emit) begin
        idx_q <= '0;
      end else if (cmd_i.load_out) begin
        idx_q <= idx_q + xfr_pkg::AddrW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_data) begin
      mem[fill_q[xfr_pkg::AddrW-1:0]] <= rx_data_i;
    end
    if (cmd_i.issue_read) begin
      rdata_q <= mem[idx_q];
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cmd_q  <= cmd_q;
      out_len_q  <= xfr_pkg::LenW'(len_q);
      out_idx_q  <= xfr_pkg::IdxW'(idx_q);
      out_byte_q <= held_zero ? '0 : rdata_q;
      out_has_q  <= !held_zero;
      out_last_q <= held_zero || (idx_inc == len_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_command_o = out_cmd_q;
  assign frame_length_o  = out_len_q;
  assign byte_index_o    = out_idx_q;
  assign payload_byte_o  = out_byte_q;
  assign has_data_o      = out_has_q;
  assign last_o          = out_last_q;

  // payload writes never run past the store
  `XFR_ASSERT(a_fill_in_range, clk_i, rst_ni, cmd_i.write_data |-> (fill_q < len_q), "payload write beyond length")
  // held length never exceeds the store depth
  `XFR_ASSERT(a_len_in_range, clk_i, rst_ni, len_q <= xfr_pkg::CntW'(xfr_pkg::MaxPayload), "held length too large")

endmodule

`default_nettype wire

// ----- rtl/xor_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// xor_frame_receiver
// byte-serial deframer: sync, command, length, payload, xor checksum
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i/in_ready_o carries one received byte (rx_data_i)
//   per transfer. frames are sync, command, length, payload[length], checksum.
//   the checksum is the xor of command, length and all payload bytes.
//   output channel out_valid_o/out_ready_i carries one result per payload
//   byte of a verified frame, last_o on the final one; an empty frame gives a
//   single result with has_data_o low. bad checksums and lengths above 32
//   drop the frame with no result.
//   in_ready_o stays high for header and payload bytes.
//   after a good checksum byte the block releases the frame in a burst,
//   one result at a time (store read, then output register load; an empty
//   frame skips the read). in_ready_o is low for the burst only.
//   a stalled receiver holds the output register; the burst waits on it.
//   the final result may still sit in the output register while new input
//   bytes are taken.
//   reset returns to sync hunting, sync byte back to 0xa5, output empty.
//   cfg_we_i/cfg_wdata_i write the sync byte; write only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xor_frame_receiver (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // sync byte register
  input  wire logic                      cfg_we_i,
  input  wire logic [xfr_pkg::ByteW-1:0] cfg_wdata_i,
  // received byte channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [xfr_pkg::ByteW-1:0] rx_data_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [xfr_pkg::ByteW-1:0]      frame_command_o,
  output logic [xfr_pkg::LenW-1:0]       frame_length_o,
  output logic [xfr_pkg::IdxW-1:0]       byte_index_o,
  output logic [xfr_pkg::ByteW-1:0]      payload_byte_o,
  output logic                           has_data_o,
  output logic                           last_o
);

  // command and status between sequencer and datapath
  xfr_pkg::xfr_cmd_t cmd;
  xfr_pkg::xfr_sts_t sts;

  // frame sequencer
  xfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // header, checksum, payload store, output register
  xfr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_data_i       (rx_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .has_data_o      (has_data_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// xor_frame_receiver testbench
// drives byte streams made of sync, command, length, payload and xor checksum
// frames, with noise and broken frames in between, and checks every released
// result against a cycle-free deframer model kept inside the bench. both
// channels stall at random, and the sync byte is moved through several values
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // one released result, packed in port order
  typedef struct packed {
    logic [xfr_pkg::ByteW-1:0] command;
    logic [xfr_pkg::LenW-1:0]  length;
    logic [xfr_pkg::IdxW-1:0]  index;
    logic [xfr_pkg::ByteW-1:0] data;
    logic                      has_data;
    logic                      last;
  } frame_result_t;

  // one directed row: the byte and, where it is obvious, the result it releases
  typedef struct packed {
    logic [xfr_pkg::ByteW-1:0] rx;
    logic                      typed;
    frame_result_t             want;
  } stim_row_t;

  typedef enum logic [2:0] {
    RX_HUNT,
    RX_CMD,
    RX_LEN,
    RX_DATA,
    RX_CHECK
  } rx_phase_e;

  localparam frame_result_t NoResult  = '0;
  localparam int            RunLimit  = 200000;  // cycles before the run is abandoned
  localparam int            IdleWait  = 80;      // covers a full 32-result burst
  localparam int            TailWait  = 40;
  localparam int            PhaseSize = 58;      // random frame bytes per sync setting
  localparam int            NumRows   = 26;

  // dut signals
  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [xfr_pkg::ByteW-1:0] cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [xfr_pkg::ByteW-1:0] rx_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [xfr_pkg::ByteW-1:0] frame_command_o;
  logic [xfr_pkg::LenW-1:0]  frame_length_o;
  logic [xfr_pkg::IdxW-1:0]  byte_index_o;
  logic [xfr_pkg::ByteW-1:0] payload_byte_o;
  logic                      has_data_o;
  logic                      last_o;

  // deframer model state
  rx_phase_e                 rx_phase;
  logic [xfr_pkg::ByteW-1:0] sync_model;
  logic [xfr_pkg::ByteW-1:0] held_cmd;
  logic [xfr_pkg::LenW-1:0]  held_len;
  logic [xfr_pkg::ByteW-1:0] run_xor;
  int                        fill;
  logic [xfr_pkg::ByteW-1:0] payload_copy [xfr_pkg::MaxPayload];

  frame_result_t    fresh_results [$];     // released by the byte just taken
  frame_result_t    expected_results [$];  // waiting for the result channel
  frame_result_t    got;
  frame_result_t    want_now;

  logic                      typed_row;
  frame_result_t             typed_want;
  bit                        steady;       // no idling on either side
  int                        mismatch_count;
  int                        frame_bytes;
  int                        phase_start;
  logic [xfr_pkg::ByteW-1:0] sync_plan [4];

  // directed rows: hunting noise, empty frame, oversized length, sync value as
  // payload, bad checksum, then a multi-byte frame left to the model
  stim_row_t directed [NumRows] = '{
    {8'h00, 1'b0, NoResult},                                      // ignored while hunting
    {8'hFF, 1'b0, NoResult},                                      // ignored while hunting
    {8'hA5, 1'b0, NoResult},
    {8'hFF, 1'b0, NoResult},                                      // command
    {8'h00, 1'b0, NoResult},                                      // empty frame
    {8'hFF, 1'b1, {8'hFF, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1}},        // checksum
    {8'hA5, 1'b0, NoResult},
    {8'h00, 1'b0, NoResult},
    {8'h21, 1'b0, NoResult},                                      // one above the buffer
    {8'hA5, 1'b0, NoResult},
    {8'h12, 1'b0, NoResult},
    {8'h01, 1'b0, NoResult},
    {8'hA5, 1'b0, NoResult},                                      // sync value as payload
    {8'hB6, 1'b1, {8'h12, 6'd1, 5'd0, 8'hA5, 1'b1, 1'b1}},
    {8'hA5, 1'b0, NoResult},
    {8'h34, 1'b0, NoResult},
    {8'h01, 1'b0, NoResult},
    {8'hFF, 1'b0, NoResult},
    {8'hCB, 1'b0, NoResult},                                      // bad checksum, dropped
    {8'hA5, 1'b0, NoResult},
    {8'h5A, 1'b0, NoResult},
    {8'h03, 1'b0, NoResult},
    {8'h01, 1'b0, NoResult},
    {8'h80, 1'b0, NoResult},
    {8'h7F, 1'b0, NoResult},
    {8'hA7, 1'b0, NoResult}
  };

  xor_frame_receiver uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_data_i       (rx_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .has_data_o      (has_data_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // advance the model by one received byte, results go to fresh_results
  function void deframe_byte(input logic [xfr_pkg::ByteW-1:0] b);
    int i;
    fresh_results.delete();
    case (rx_phase)
      RX_HUNT: begin
        // anything but the sync byte is dropped here
        if (b == sync_model) rx_phase = RX_CMD;
      end
      RX_CMD: begin
        held_cmd = b;
        run_xor  = b;
        rx_phase = RX_LEN;
      end
      RX_LEN: begin
        fill = 0;
        if (b > xfr_pkg::MaxPayload) begin
          rx_phase = RX_HUNT;
        end else begin
          held_len = b[xfr_pkg::LenW-1:0];
          run_xor  = run_xor ^ b;
          rx_phase = (b == 0) ? RX_CHECK : RX_DATA;
        end
      end
      RX_DATA: begin
        // sync value mid-frame is plain payload
        payload_copy[fill] = b;
        run_xor = run_xor ^ b;
        fill++;
        if (fill >= held_len) rx_phase = RX_CHECK;
      end
      RX_CHECK: begin
        if (b == run_xor) begin
          if (held_len == 0) begin
            fresh_results.push_back({held_cmd, held_len, 5'd0, 8'h00, 1'b0, 1'b1});
          end else begin
            for (i = 0; i < held_len; i++) begin
              fresh_results.push_back({held_cmd, held_len, i[xfr_pkg::IdxW-1:0],
                                       payload_copy[i], 1'b1, (i + 1 == held_len)});
            end
          end
        end
        // good or bad, the checksum ends the frame
        rx_phase = RX_HUNT;
      end
      default: begin
        rx_phase = RX_HUNT;
      end
    endcase
  endfunction

  // check results first, then predict from the byte taken at the same edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_phase   = RX_HUNT;
      sync_model = xfr_pkg::SyncReset;
      held_cmd   = '0;
      held_len   = '0;
      run_xor    = '0;
      fill       = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {frame_command_o, frame_length_o, byte_index_o, payload_byte_o,
               has_data_o, last_o};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result cmd=%h len=%0d idx=%0d data=%h has=%b last=%b",
                     $realtime, got.command, got.length, got.index, got.data,
                     got.has_data, got.last);
          end
        end else begin
          want_now = expected_results.pop_front();
          if (got !== want_now) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected cmd=%h len=%0d idx=%0d data=%h has=%b last=%b",
                       want_now.command, want_now.length, want_now.index, want_now.data,
                       want_now.has_data, want_now.last);
              $display("  actual   cmd=%h len=%0d idx=%0d data=%h has=%b last=%b",
                       got.command, got.length, got.index, got.data, got.has_data,
                       got.last);
            end
          end
        end
      end
      if (cfg_we_i) sync_model = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        deframe_byte(rx_data_i);
        if (typed_row) begin
          expected_results.push_back(typed_want);
        end else begin
          foreach (fresh_results[i]) expected_results.push_back(fresh_results[i]);
        end
      end
    end
  end

  // receiver side stalls
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 36);
  end

  // present one byte and hold it until the transfer
  task send_byte(input logic [xfr_pkg::ByteW-1:0] b, input logic typed,
                 input frame_result_t want);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_data_i  <= b;
    typed_row  = typed;
    typed_want = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // a little hunting noise, then one frame; some oversized, some with bad checksums
  task send_frame(input logic [xfr_pkg::ByteW-1:0] sync);
    int                        noise;
    int                        roll;
    int                        k;
    logic [xfr_pkg::ByteW-1:0] len;
    logic [xfr_pkg::ByteW-1:0] cmd;
    logic [xfr_pkg::ByteW-1:0] b;
    logic [xfr_pkg::ByteW-1:0] chk;
    noise = $urandom_range(0, 2);
    for (k = 0; k < noise; k++) begin
      b = 8'($urandom);
      if (b == sync) b = b ^ 8'h01;
      send_byte(b, 1'b0, NoResult);
    end
    roll = $urandom_range(99);
    if (roll < 6)       len = 8'($urandom_range(xfr_pkg::MaxPayload + 1, 255));
    else if (roll < 10) len = 8'(xfr_pkg::MaxPayload);
    else if (roll < 16) len = 8'($urandom_range(9, xfr_pkg::MaxPayload - 1));
    else if (roll < 28) len = 8'h00;
    else                len = 8'($urandom_range(1, 8));
    cmd = 8'($urandom);
    send_byte(sync, 1'b0, NoResult);
    send_byte(cmd, 1'b0, NoResult);
    send_byte(len, 1'b0, NoResult);
    frame_bytes += 3;
    if (len <= xfr_pkg::MaxPayload) begin
      chk = cmd ^ len;
      for (k = 0; k < len; k++) begin
        b = ($urandom_range(9) == 0) ? sync : 8'($urandom);
        chk = chk ^ b;
        send_byte(b, 1'b0, NoResult);
      end
      // flip one checksum bit now and then
      if ($urandom_range(99) < 12) chk = chk ^ (8'h01 << $urandom_range(7));
      send_byte(chk, 1'b0, NoResult);
      frame_bytes += len + 1;
    end
  endtask

  // stop sending and wait for every outstanding result
  task drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task write_sync(input logic [xfr_pkg::ByteW-1:0] value);
    drain_results();
    repeat (IdleWait) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // run watchdog
  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    rx_data_i      = '0;
    out_ready_i    = 1'b0;
    typed_row      = 1'b0;
    typed_want     = NoResult;
    steady         = 1'b0;
    mismatch_count = 0;
    frame_bytes    = 0;
    sync_plan[0]   = 8'h00;
    sync_plan[1]   = 8'hFF;
    sync_plan[2]   = 8'($urandom_range(1, 254));
    sync_plan[3]   = xfr_pkg::SyncReset;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows at the reset sync value
    foreach (directed[r]) send_byte(directed[r].rx, directed[r].typed, directed[r].want);

    // random frames under each sync setting, sender held off before every write
    foreach (sync_plan[p]) begin
      write_sync(sync_plan[p]);
      phase_start = frame_bytes;
      while (frame_bytes - phase_start < PhaseSize) begin
        steady = (p == 1) && (frame_bytes - phase_start >= 15)
                 && (frame_bytes - phase_start < 55);
        send_frame(sync_plan[p]);
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (TailWait) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/xfr_pkg.sv
rtl/xfr_ctrl.sv
rtl/xfr_datapath.sv
rtl/xor_frame_receiver.sv
sim/tb.sv
